>>> design/rsnh_pkg.sv
// ----------------------------------------------------------------------------
// rsnh_pkg
// shared types and constants of the ray to wall-segment nearest-hit block
// ----------------------------------------------------------------------------
package rsnh_pkg;

    localparam int MaxSegmentsDef = 64;
    localparam int FracBitsDef    = 16;

    localparam int CoordW = 24;   // Q8.16 coordinate
    localparam int DirW   = 18;   // view direction component
    localparam int CountW = 7;    // segment_count register
    localparam int SlotW  = 6;
    localparam int ColorW = 24;
    localparam int DistW  = 23;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 24;

    localparam int DiffW = CoordW + 1;        // coordinate difference
    localparam int ProdW = 2 * DiffW;         // shared multiplier product
    localparam int AccW  = ProdW + 1;         // den / numerators
    localparam int MagW  = ProdW;             // normalized den / numerator magnitude
    localparam int QuotW = DiffW;             // divider quotient magnitude
    localparam int DotW  = DiffW + DirW + 1;  // projected distance before scaling
    localparam int SegW  = 4 * CoordW + ColorW;

    localparam logic [DistW-1:0]  DistMax = {DistW{1'b1}};
    localparam logic [ColorW-1:0] White   = {ColorW{1'b1}};

    typedef enum logic [CfgIdxW-1:0] {
        CFG_VIEWER_X   = 3'd0,
        CFG_VIEWER_Y   = 3'd1,
        CFG_VIEW_DIR_X = 3'd2,
        CFG_VIEW_DIR_Y = 3'd3,
        CFG_SEG_COUNT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_MUL,
        ST_NORM,
        ST_TEST,
        ST_DIVX,
        ST_DIVY,
        ST_DOT,
        ST_PICK,
        ST_NEXT,
        ST_DONE
    } t_state;

endpackage

>>> design/ray_segment_nearest_hit_top.sv
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit_top
// nearest wall-segment hit along a ray from the viewer, with segment table
// ----------------------------------------------------------------------------
// A load item (mode 0) writes one segment and its color into the table in
// the cycle it is accepted and gives no result. A cast item (mode 1) tests
// the first segment_count entries one after the other with a single shared
// 25x25 multiplier and one bit-serial multiply-divide unit, and gives one
// result item. Per tested segment: the table read, the cross products, then
// the denominator check; a parallel segment leaves there, otherwise the
// range check follows and a missed segment leaves there. A hit adds two
// divisions, the dot product and the selection; the two divisions dominate
// a cast. The block takes no item while a cast runs. The result sits in an
// output register, so the next item is accepted while it waits. Coordinates
// are signed Q8.16 fixed point.
// ----------------------------------------------------------------------------
module ray_segment_nearest_hit_top #(
    parameter int MAX_SEGMENTS = rsnh_pkg::MaxSegmentsDef,
    parameter int FRAC_BITS    = rsnh_pkg::FracBitsDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic [rsnh_pkg::SlotW-1:0]          i_slot,
    input  logic signed [rsnh_pkg::CoordW-1:0]  i_point_a_x,
    input  logic signed [rsnh_pkg::CoordW-1:0]  i_point_a_y,
    input  logic signed [rsnh_pkg::CoordW-1:0]  i_point_b_x,
    input  logic signed [rsnh_pkg::CoordW-1:0]  i_point_b_y,
    input  logic [rsnh_pkg::ColorW-1:0]         i_color_in,
    // result items
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic signed [rsnh_pkg::CoordW-1:0]  o_hit_x,
    output logic signed [rsnh_pkg::CoordW-1:0]  o_hit_y,
    output logic [rsnh_pkg::DistW-1:0]          o_distance,
    output logic [rsnh_pkg::ColorW-1:0]         o_hit_color,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rsnh_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [rsnh_pkg::CfgDataW-1:0]       i_cfg_data
);

    localparam int CoordW = rsnh_pkg::CoordW;
    localparam int DirW   = rsnh_pkg::DirW;
    localparam int DiffW  = rsnh_pkg::DiffW;
    localparam int ProdW  = rsnh_pkg::ProdW;
    localparam int AccW   = rsnh_pkg::AccW;
    localparam int MagW   = rsnh_pkg::MagW;
    localparam int QuotW  = rsnh_pkg::QuotW;
    localparam int DotW   = rsnh_pkg::DotW;
    localparam int DistW  = rsnh_pkg::DistW;
    localparam int ColorW = rsnh_pkg::ColorW;
    localparam int CountW = rsnh_pkg::CountW;
    localparam int SegW   = rsnh_pkg::SegW;
    localparam int AW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW     = $clog2(MAX_SEGMENTS + 1);
    localparam logic [DirW-1:0] DirReset = DirW'(64'd1 << FRAC_BITS);

    // configuration registers
    logic signed [CoordW-1:0] r_viewer_x;
    logic signed [CoordW-1:0] r_viewer_y;
    logic signed [DirW-1:0]   r_dir_x;
    logic signed [DirW-1:0]   r_dir_y;
    logic [CountW-1:0]        r_seg_count;

    // sequencer
    rsnh_pkg::t_state r_state;
    rsnh_pkg::t_state n_state;
    logic [2:0]       r_step;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_n;

    // per cast and per segment operands
    logic signed [DiffW-1:0]  r_x43, r_y43;
    logic signed [CoordW-1:0] r_ax, r_ay;
    logic signed [DiffW-1:0]  r_x21, r_y21, r_x13, r_y13;
    logic [ColorW-1:0]        r_color;
    logic signed [AccW-1:0]   r_den, r_na, r_nb;
    logic signed [CoordW-1:0] r_hx, r_hy;
    logic signed [ProdW-1:0]  r_prod;
    logic signed [DotW-1:0]   r_raw;

    // best hit so far
    logic                     r_found;
    logic signed [DotW-1:0]   r_best;
    logic signed [CoordW-1:0] r_bx, r_by;
    logic [ColorW-1:0]        r_bcol;

    // result register
    logic                     r_out_valid;
    logic                     r_out_hit;
    logic signed [CoordW-1:0] r_out_x, r_out_y;
    logic [DistW-1:0]         r_out_dist;
    logic [ColorW-1:0]        r_out_color;

    logic in_acc;
    logic load_we;
    logic ram_re;
    logic [SegW-1:0] ram_rdata;
    logic div_start;
    logic div_done;
    logic signed [DiffW-1:0] div_m;
    logic signed [QuotW:0]   div_quot;
    logic signed [DiffW-1:0] mul_a, mul_b;
    logic seg_miss;
    logic last_seg;
    logic out_load;
    logic [DotW-1:0]  dist_sh;
    logic [DistW-1:0] dist_val;
    logic signed [CoordW-1:0] hit_base;
    logic signed [QuotW:0] hit_sum;

    assign o_ready     = (r_state == rsnh_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid & o_ready;
    assign load_we     = in_acc & ~i_mode & (int'(i_slot) < MAX_SEGMENTS);
    assign last_seg    = (CW'(r_idx + 1'b1) == r_n);
    assign out_load    = (r_state == rsnh_pkg::ST_DONE) & (~r_out_valid | i_ready);

    // segment table, one row per slot: start, end, color
    rsnh_ram #(
        .WIDTH (SegW),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata ({i_point_a_x, i_point_a_y, i_point_b_x, i_point_b_y, i_color_in}),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    rsnh_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_na[MagW-1:0]),
        .i_den   (r_den[MagW-1:0]),
        .i_m     (div_m),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // parametric test fails: sign or range of either numerator
    assign seg_miss = (r_na < 0) || (r_na > r_den) || (r_nb < 0) || (r_nb > r_den);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsnh_pkg::ST_IDLE: begin
                if (in_acc && i_mode) begin
                    n_state = (int'(r_seg_count) == 0) ? rsnh_pkg::ST_DONE
                                                       : rsnh_pkg::ST_READ;
                end
            end
            rsnh_pkg::ST_READ:  n_state = rsnh_pkg::ST_FETCH;
            rsnh_pkg::ST_FETCH: n_state = rsnh_pkg::ST_MUL;
            rsnh_pkg::ST_MUL: begin
                if (r_step == 3'd6) begin
                    n_state = rsnh_pkg::ST_NORM;
                end
            end
            rsnh_pkg::ST_NORM: begin
                // parallel segment never hits
                n_state = (r_den == '0) ? rsnh_pkg::ST_NEXT : rsnh_pkg::ST_TEST;
            end
            rsnh_pkg::ST_TEST: begin
                n_state = seg_miss ? rsnh_pkg::ST_NEXT : rsnh_pkg::ST_DIVX;
            end
            rsnh_pkg::ST_DIVX: begin
                if (div_done) begin
                    n_state = rsnh_pkg::ST_DIVY;
                end
            end
            rsnh_pkg::ST_DIVY: begin
                if (div_done) begin
                    n_state = rsnh_pkg::ST_DOT;
                end
            end
            rsnh_pkg::ST_DOT: begin
                if (r_step == 3'd2) begin
                    n_state = rsnh_pkg::ST_PICK;
                end
            end
            rsnh_pkg::ST_PICK: n_state = rsnh_pkg::ST_NEXT;
            rsnh_pkg::ST_NEXT: begin
                n_state = last_seg ? rsnh_pkg::ST_DONE : rsnh_pkg::ST_READ;
            end
            rsnh_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = rsnh_pkg::ST_IDLE;
                end
            end
            default: n_state = rsnh_pkg::ST_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        ram_re    = 1'b0;
        div_start = 1'b0;
        div_m     = r_x21;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            rsnh_pkg::ST_READ: ram_re = 1'b1;
            rsnh_pkg::ST_TEST: begin
                div_start = ~seg_miss;
                div_m     = r_x21;
            end
            rsnh_pkg::ST_DIVX: begin
                div_start = div_done;
                div_m     = r_y21;
            end
            rsnh_pkg::ST_MUL: begin
                unique case (r_step)
                    3'd0: begin mul_a = r_y43; mul_b = r_x21; end
                    3'd1: begin mul_a = r_x43; mul_b = r_y21; end
                    3'd2: begin mul_a = r_x43; mul_b = r_y13; end
                    3'd3: begin mul_a = r_y43; mul_b = r_x13; end
                    3'd4: begin mul_a = r_x21; mul_b = r_y13; end
                    3'd5: begin mul_a = r_y21; mul_b = r_x13; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            rsnh_pkg::ST_DOT: begin
                if (r_step == 3'd0) begin
                    mul_a = DiffW'(r_hx) - DiffW'(r_viewer_x);
                    mul_b = DiffW'(r_dir_x);
                end else if (r_step == 3'd1) begin
                    mul_a = DiffW'(r_hy) - DiffW'(r_viewer_y);
                    mul_b = DiffW'(r_dir_y);
                end
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsnh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viewer_x  <= '0;
            r_viewer_y  <= '0;
            r_dir_x     <= DirReset;
            r_dir_y     <= '0;
            r_seg_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rsnh_pkg::CFG_VIEWER_X:   r_viewer_x  <= i_cfg_data[CoordW-1:0];
                rsnh_pkg::CFG_VIEWER_Y:   r_viewer_y  <= i_cfg_data[CoordW-1:0];
                rsnh_pkg::CFG_VIEW_DIR_X: r_dir_x     <= i_cfg_data[DirW-1:0];
                rsnh_pkg::CFG_VIEW_DIR_Y: r_dir_y     <= i_cfg_data[DirW-1:0];
                rsnh_pkg::CFG_SEG_COUNT:  r_seg_count <= i_cfg_data[CountW-1:0];
                default: begin
                    r_seg_count <= r_seg_count;
                end
            endcase
        end
    end

    // sequencer counters and best-hit tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_idx   <= '0;
            r_n     <= '0;
            r_found <= 1'b0;
        end else begin
            if (n_state != r_state) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + 1'b1;
            end
            if (in_acc && i_mode) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                // count above the table size tests the whole table
                r_n <= (int'(r_seg_count) > MAX_SEGMENTS) ? CW'(MAX_SEGMENTS)
                                                          : CW'(r_seg_count);
            end
            if (r_state == rsnh_pkg::ST_NEXT) begin
                r_idx <= CW'(r_idx + 1'b1);
            end
            if (r_state == rsnh_pkg::ST_PICK && (!r_found || r_raw < r_best)) begin
                r_found <= 1'b1;
            end
        end
    end

    // first division gives the x offset, second the y offset
    assign hit_base = (r_state == rsnh_pkg::ST_DIVY) ? r_ay : r_ax;
    assign hit_sum  = (QuotW + 1)'(hit_base) + div_quot;

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_acc && i_mode) begin
            r_x43 <= DiffW'(i_point_a_x) - DiffW'(r_viewer_x);
            r_y43 <= DiffW'(i_point_a_y) - DiffW'(r_viewer_y);
        end
        unique case (r_state)
            rsnh_pkg::ST_FETCH: begin
                r_ax    <= ram_rdata[4*CoordW+ColorW-1 -: CoordW];
                r_ay    <= ram_rdata[3*CoordW+ColorW-1 -: CoordW];
                r_x21   <= DiffW'($signed(ram_rdata[2*CoordW+ColorW-1 -: CoordW]))
                         - DiffW'($signed(ram_rdata[4*CoordW+ColorW-1 -: CoordW]));
                r_y21   <= DiffW'($signed(ram_rdata[CoordW+ColorW-1 -: CoordW]))
                         - DiffW'($signed(ram_rdata[3*CoordW+ColorW-1 -: CoordW]));
                r_x13   <= DiffW'($signed(ram_rdata[4*CoordW+ColorW-1 -: CoordW]))
                         - DiffW'(r_viewer_x);
                r_y13   <= DiffW'($signed(ram_rdata[3*CoordW+ColorW-1 -: CoordW]))
                         - DiffW'(r_viewer_y);
                r_color <= ram_rdata[ColorW-1:0];
            end
            rsnh_pkg::ST_MUL: begin
                // product of the previous step lands here
                unique case (r_step)
                    3'd1: r_den <= AccW'(r_prod);
                    3'd2: r_den <= r_den - AccW'(r_prod);
                    3'd3: r_na  <= AccW'(r_prod);
                    3'd4: r_na  <= r_na - AccW'(r_prod);
                    3'd5: r_nb  <= AccW'(r_prod);
                    3'd6: r_nb  <= r_nb - AccW'(r_prod);
                    default: r_den <= r_den;
                endcase
            end
            rsnh_pkg::ST_NORM: begin
                // make the denominator positive
                if (r_den < 0) begin
                    r_den <= -r_den;
                    r_na  <= -r_na;
                    r_nb  <= -r_nb;
                end
            end
            rsnh_pkg::ST_DIVX: begin
                if (div_done) begin
                    r_hx <= hit_sum[CoordW-1:0];
                end
            end
            rsnh_pkg::ST_DIVY: begin
                if (div_done) begin
                    r_hy <= hit_sum[CoordW-1:0];
                end
            end
            rsnh_pkg::ST_DOT: begin
                if (r_step == 3'd1) begin
                    r_raw <= DotW'(r_prod);
                end else if (r_step == 3'd2) begin
                    r_raw <= r_raw + DotW'(r_prod);
                end
            end
            rsnh_pkg::ST_PICK: begin
                // strict compare keeps the earlier slot on a tie
                if (!r_found || r_raw < r_best) begin
                    r_best <= r_raw;
                    r_bx   <= r_hx;
                    r_by   <= r_hy;
                    r_bcol <= r_color;
                end
            end
            default: begin
                r_raw <= r_raw;
            end
        endcase
    end

    // distance: scale down, clamp negative to zero and large to maximum; no hit gives maximum
    assign dist_sh = DotW'($unsigned(r_best) >> FRAC_BITS);
    always_comb begin
        if (!r_found) begin
            dist_val = rsnh_pkg::DistMax;
        end else if (r_best < 0) begin
            dist_val = '0;
        end else if (dist_sh > DotW'(rsnh_pkg::DistMax)) begin
            dist_val = rsnh_pkg::DistMax;
        end else begin
            dist_val = dist_sh[DistW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit   <= r_found;
            r_out_x     <= r_found ? r_bx : '0;
            r_out_y     <= r_found ? r_by : '0;
            r_out_dist  <= dist_val;
            r_out_color <= r_found ? r_bcol : rsnh_pkg::White;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_hit_x     = r_out_x;
    assign o_hit_y     = r_out_y;
    assign o_distance  = r_out_dist;
    assign o_hit_color = r_out_color;

endmodule

>>> design/rsnh_ram.sv
// ----------------------------------------------------------------------------
// rsnh_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rsnh_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rsnh_muldiv.sv
// ----------------------------------------------------------------------------
// rsnh_muldiv
// bit-serial trunc(n * m / d) for 0 <= n <= d, one bit of m per cycle
// ----------------------------------------------------------------------------
module rsnh_muldiv (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rsnh_pkg::MagW-1:0]        i_num,
    input  logic [rsnh_pkg::MagW-1:0]        i_den,
    input  logic signed [rsnh_pkg::DiffW-1:0] i_m,
    output logic                             o_done,
    output logic signed [rsnh_pkg::QuotW:0]  o_quot
);

    localparam int MagW  = rsnh_pkg::MagW;
    localparam int QuotW = rsnh_pkg::QuotW;
    localparam int TW    = MagW + 2;
    localparam int CntW  = $clog2(QuotW + 1);

    logic [MagW-1:0]  r_rem;
    logic [QuotW-1:0] r_quot;
    logic [QuotW-1:0] r_mag;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_neg;

    logic [TW-1:0] t;
    logic [TW-1:0] d1;
    logic [TW-1:0] d2;
    logic [TW-1:0] t_rem;
    logic [1:0]    qbit;

    // remainder stays below den, so the shifted sum stays below three times den
    always_comb begin
        t  = {1'b0, r_rem, 1'b0} + (r_mag[QuotW-1] ? TW'(i_num) : '0);
        d1 = TW'(i_den);
        d2 = {1'b0, i_den, 1'b0};
        if (t >= d2) begin
            t_rem = t - d2;
            qbit  = 2'd2;
        end else if (t >= d1) begin
            t_rem = t - d1;
            qbit  = 2'd1;
        end else begin
            t_rem = t;
            qbit  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(QuotW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_m[QuotW-1];
            r_mag  <= i_m[QuotW-1] ? QuotW'(-i_m) : QuotW'(i_m);
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_mag  <= {r_mag[QuotW-2:0], 1'b0};
            r_rem  <= t_rem[MagW-1:0];
            r_quot <= QuotW'({r_quot, 1'b0} + QuotW'(qbit));
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});

endmodule

>>> sim/ray_segment_nearest_hit_top_test.sv
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit_top_test
// self-checking bench for the ray to wall-segment nearest-hit block
// ----------------------------------------------------------------------------
// Segments are loaded into the table and rays are cast against them through
// the item port, with random idle cycles on both sides. Every accepted cast
// without a typed-in expectation goes through a local predictor that keeps
// its own copy of the table and of the view registers, and each result
// item is compared field by field with the oldest prediction. The view
// registers are changed only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module ray_segment_nearest_hit_top_test;

    localparam int SlotW    = rsnh_pkg::SlotW;
    localparam int CoordW   = rsnh_pkg::CoordW;
    localparam int ColorW   = rsnh_pkg::ColorW;
    localparam int DistW    = rsnh_pkg::DistW;
    localparam int DirW     = rsnh_pkg::DirW;
    localparam int CountW   = rsnh_pkg::CountW;
    localparam int CfgIdxW  = rsnh_pkg::CfgIdxW;
    localparam int CfgDataW = rsnh_pkg::CfgDataW;
    localparam int FracBits = rsnh_pkg::FracBitsDef;
    localparam logic [DistW-1:0]   DistMax = rsnh_pkg::DistMax;
    localparam logic [ColorW-1:0]  White   = rsnh_pkg::White;
    localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

    localparam int NSeg        = rsnh_pkg::MaxSegmentsDef;
    localparam int StallLimit  = 200000;
    localparam int DrainCycles = 6000;

    typedef struct packed {
        logic                     mode;
        logic [SlotW-1:0]         slot;
        logic signed [CoordW-1:0] ax;
        logic signed [CoordW-1:0] ay;
        logic signed [CoordW-1:0] bx;
        logic signed [CoordW-1:0] by;
        logic [ColorW-1:0]        color;
    } t_item;

    typedef struct packed {
        logic                     hit;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic [DistW-1:0]         distance;
        logic [ColorW-1:0]        color;
    } t_hit;

    // directed row: item, plus an optional typed-in expectation
    typedef struct {
        t_item item;
        bit    fixed;
        t_hit  want;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic                     i_mode;
    logic [SlotW-1:0]         i_slot;
    logic signed [CoordW-1:0] i_point_a_x;
    logic signed [CoordW-1:0] i_point_a_y;
    logic signed [CoordW-1:0] i_point_b_x;
    logic signed [CoordW-1:0] i_point_b_y;
    logic [ColorW-1:0]        i_color_in;
    logic                     o_valid;
    logic                     i_ready;
    logic                     o_hit;
    logic signed [CoordW-1:0] o_hit_x;
    logic signed [CoordW-1:0] o_hit_y;
    logic [DistW-1:0]         o_distance;
    logic [ColorW-1:0]        o_hit_color;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CfgIdxW-1:0]       i_cfg_index;
    logic [CfgDataW-1:0]      i_cfg_data;

    ray_segment_nearest_hit_top dut (.*);

    // predictor state: view registers and segment table
    longint view_x, view_y, dir_x, dir_y;
    int     seg_limit;
    longint tab_ax[NSeg], tab_ay[NSeg], tab_bx[NSeg], tab_by[NSeg];
    logic [ColorW-1:0] tab_color[NSeg];

    t_hit   pending_hits[$];
    int     errors;
    int     quiet_cycles;
    bit     rx_hold;     // long receiver hold-off request
    bit     calm;        // no idling on either side

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("error: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic queue_hit(t_hit h);
        pending_hits = {pending_hits, h};
    endtask

    // trunc(n * m / d), 0 <= n <= d, d > 0; 128-bit arithmetic is exact here
    function automatic longint scale_toward_zero(longint n, longint m, longint d);
        logic signed [127:0] p;
        p = $signed(128'(n)) * $signed(128'(m));
        return longint'(p / $signed(128'(d)));
    endfunction

    function automatic t_hit nearest_hit(t_item it);
        t_hit   r;
        bit     found;
        longint best, bx, by, x21, y21, x43, y43, x13, y13, den, na, nb, hx, hy, raw;
        int     n;
        found = 0; best = 0; bx = 0; by = 0;
        r.color = White;
        n = (seg_limit > NSeg) ? NSeg : seg_limit;
        for (int i = 0; i < n; i++) begin
            x21 = tab_bx[i] - tab_ax[i];
            y21 = tab_by[i] - tab_ay[i];
            x43 = longint'(it.ax) - view_x;
            y43 = longint'(it.ay) - view_y;
            x13 = tab_ax[i] - view_x;
            y13 = tab_ay[i] - view_y;
            den = y43 * x21 - x43 * y21;
            na  = x43 * y13 - y43 * x13;
            nb  = x21 * y13 - y21 * x13;
            if (den == 0) continue;
            if (den < 0) begin
                den = -den; na = -na; nb = -nb;
            end
            if (na < 0 || na > den || nb < 0 || nb > den) continue;
            hx  = tab_ax[i] + scale_toward_zero(na, x21, den);
            hy  = tab_ay[i] + scale_toward_zero(na, y21, den);
            raw = (hx - view_x) * dir_x + (hy - view_y) * dir_y;
            if (!found || raw < best) begin
                found = 1; best = raw; bx = hx; by = hy;
                r.color = tab_color[i];
            end
        end
        r.hit = found;
        r.x   = bx[CoordW-1:0];
        r.y   = by[CoordW-1:0];
        if (!found) r.distance = DistMax;
        else if (best < 0) r.distance = '0;
        else if ((best >>> FracBits) > longint'(DistMax)) r.distance = DistMax;
        else r.distance = DistW'(best >>> FracBits);
        return r;
    endfunction

    // apply an accepted item to the predictor
    task automatic track_item(t_item it);
        if (!it.mode) begin
            tab_ax[it.slot] = it.ax; tab_ay[it.slot] = it.ay;
            tab_bx[it.slot] = it.bx; tab_by[it.slot] = it.by;
            tab_color[it.slot] = it.color;
        end else begin
            queue_hit(nearest_hit(it));
        end
    endtask

    task automatic put_item(t_item it);
        i_valid     = 1'b1;
        i_mode      = it.mode;
        i_slot      = it.slot;
        i_point_a_x = it.ax;
        i_point_a_y = it.ay;
        i_point_b_x = it.bx;
        i_point_b_y = it.by;
        i_color_in  = it.color;
        do @(posedge i_clk); while (!o_ready);
        track_item(it);
        @(negedge i_clk);
        i_valid = 1'b0;
        if (!calm) while ($urandom_range(99) < 14) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(rsnh_pkg::t_cfg_idx idx, logic [CfgDataW-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rsnh_pkg::CFG_VIEWER_X:   view_x = longint'($signed(val));
            rsnh_pkg::CFG_VIEWER_Y:   view_y = longint'($signed(val));
            rsnh_pkg::CFG_VIEW_DIR_X: dir_x = longint'($signed(val[DirW-1:0]));
            rsnh_pkg::CFG_VIEW_DIR_Y: dir_y = longint'($signed(val[DirW-1:0]));
            rsnh_pkg::CFG_SEG_COUNT:  seg_limit = int'(val[CountW-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [CoordW-1:0] rand_coord(bit wide);
        if (wide) return CoordW'($urandom);
        return CoordW'($signed($urandom_range(2 * 1310720)) - 1310720);
    endfunction

    function automatic t_item load_item(int slot, bit wide);
        t_item it;
        it.mode = 1'b0; it.slot = SlotW'(slot);
        it.ax = rand_coord(wide); it.ay = rand_coord(wide);
        it.bx = rand_coord(wide); it.by = rand_coord(wide);
        it.color = ColorW'($urandom);
        return it;
    endfunction

    function automatic t_item cast_item(bit wide);
        t_item it;
        it = load_item($urandom_range(63), wide);
        it.mode = 1'b1;
        return it;
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                rx_hold = 0;
            end
            i_ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    // result checker
    initial begin
        t_hit want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_hits.size() == 0) begin
                    $display("error: result item with nothing expected");
                    errors++;
                end else begin
                    want = pending_hits.pop_front();
                    if (o_hit !== want.hit) report("hit", o_hit, want.hit);
                    if (o_hit_x !== want.x) report("hit_x", o_hit_x, want.x);
                    if (o_hit_y !== want.y) report("hit_y", o_hit_y, want.y);
                    if (o_distance !== want.distance)
                        report("distance", o_distance, want.distance);
                    if (o_hit_color !== want.color)
                        report("hit_color", o_hit_color, want.color);
                end
            end
        end
    end

    // watchdog on cycles with no accepted item on any channel
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
                $display("ray_segment_nearest_hit_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_row   rows[$];
        t_row   row;
        t_hit   miss;
        t_item  it;
        int     nseg;
        errors = 0; rx_hold = 0; calm = 0;
        view_x = 0; view_y = 0; dir_x = 65536; dir_y = 0; seg_limit = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_mode = 1'b0; i_slot = '0;
        i_point_a_x = '0; i_point_a_y = '0; i_point_b_x = '0; i_point_b_y = '0;
        i_color_in = '0; i_cfg_valid = 1'b0; i_cfg_index = rsnh_pkg::CFG_VIEWER_X;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        miss = '{hit: 1'b0, x: '0, y: '0, distance: DistMax, color: White};

        // directed: cast with no segments after reset gives the no-hit result
        row.fixed = 1; row.want = miss;
        row.item = '{mode: 1'b1, slot: '1, ax: 24'sh7fffff, ay: -24'sh800000,
                     bx: '0, by: '0, color: '0};
        rows = {rows, row};
        // segments: wall at x=4 and a nearer wall at x=2 (hit), a parallel
        // segment, a segment behind the viewer, an extreme-coordinate one,
        // and a duplicate of the nearer wall to check the tie rule
        row.fixed = 0;
        row.item = '{1'b0, 6'd0, 24'sd262144, -24'sd262144, 24'sd262144, 24'sd262144, 24'h123456};
        rows = {rows, row};
        row.item = '{1'b0, 6'd1, 24'sd131072, -24'sd131072, 24'sd131072, 24'sd131072, 24'hff0000};
        rows = {rows, row};
        row.item = '{1'b0, 6'd2, 24'sd0, 24'sd65536, 24'sd655360, 24'sd65536, 24'h00ff00};
        rows = {rows, row};
        row.item = '{1'b0, 6'd3, -24'sd131072, -24'sd65536, -24'sd131072, 24'sd65536, 24'h0000ff};
        rows = {rows, row};
        row.item = '{1'b0, 6'd4, 24'sh7fffff, -24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'hffffff};
        rows = {rows, row};
        row.item = '{1'b0, 6'd5, 24'sd131072, -24'sd131072, 24'sd131072, 24'sd131072, 24'h000000};
        rows = {rows, row};
        // casts toward +x, toward -x (negative distance), extreme targets, a target at the viewer
        row.item = '{1'b1, 6'd0, 24'sd655360, 24'sd0, '0, '0, '0};
        rows = {rows, row};
        row.item = '{1'b1, 6'd0, -24'sd655360, 24'sd0, '0, '0, '0};
        rows = {rows, row};
        row.item = '{1'b1, 6'd63, 24'sh7fffff, 24'sh7fffff, '1, '1, '1};
        rows = {rows, row};
        row.item = '{1'b1, 6'd0, 24'sh7fffff, 24'sd0, '0, '0, '0};
        rows = {rows, row};
        row.item = '{1'b1, 6'd0, 24'sd0, 24'sd0, '0, '0, '0};
        rows = {rows, row};

        for (int r = 0; r < rows.size(); r++) begin
            if (r == 7) begin
                // all six segments loaded: enable them while idle
                wait_drained();
                write_reg(rsnh_pkg::CFG_SEG_COUNT, 24'd6);
            end
            if (rows[r].fixed && rows[r].item.mode) begin
                it = rows[r].item;
                i_valid = 1'b1; i_mode = it.mode; i_slot = it.slot;
                i_point_a_x = it.ax; i_point_a_y = it.ay;
                i_point_b_x = it.bx; i_point_b_y = it.by; i_color_in = it.color;
                do @(posedge i_clk); while (!o_ready);
                queue_hit(rows[r].want);
                @(negedge i_clk);
                i_valid = 1'b0;
            end else begin
                put_item(rows[r].item);
            end
        end

        // random phases, each with its own view setting
        for (int phase = 0; phase < 10; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(rsnh_pkg::CFG_VIEWER_X, 24'h7fffff);
                    write_reg(rsnh_pkg::CFG_VIEWER_Y, 24'h800000);
                    write_reg(rsnh_pkg::CFG_VIEW_DIR_X, 24'h30000);
                    write_reg(rsnh_pkg::CFG_VIEW_DIR_Y, 24'h10000);
                end
                1: begin
                    write_reg(rsnh_pkg::CFG_VIEWER_X, 24'h800000);
                    write_reg(rsnh_pkg::CFG_VIEWER_Y, 24'h7fffff);
                    write_reg(rsnh_pkg::CFG_VIEW_DIR_X, 24'h10000);
                    write_reg(rsnh_pkg::CFG_VIEW_DIR_Y, 24'h30000);
                end
                default: begin
                    write_reg(rsnh_pkg::CFG_VIEWER_X, CfgDataW'(rand_coord(0)));
                    write_reg(rsnh_pkg::CFG_VIEWER_Y, CfgDataW'(rand_coord(0)));
                    write_reg(rsnh_pkg::CFG_VIEW_DIR_X,
                              CfgDataW'($urandom_range(131072) - 65536));
                    write_reg(rsnh_pkg::CFG_VIEW_DIR_Y,
                              CfgDataW'($urandom_range(131072) - 65536));
                end
            endcase
            // unknown index
            write_reg(rsnh_pkg::t_cfg_idx'(CfgIdxUnused), CfgDataW'($urandom));
            // mostly small tables, a full one and count beyond the table once
            nseg = (phase == 3) ? 64 : $urandom_range(1, 8);
            for (int s = 0; s < nseg; s++) put_item(load_item(s, phase == 1));
            write_reg(rsnh_pkg::CFG_SEG_COUNT, (phase == 3) ? 24'd127 : CfgDataW'(nseg));
            calm = (phase == 5);
            if (phase == 4) rx_hold = 1;
            for (int k = 0; k < 130; k++) begin
                if ($urandom_range(3) == 0) put_item(load_item($urandom_range(nseg - 1), 0));
                else put_item(cast_item((phase <= 1) || $urandom_range(9) == 0));
                if (phase == 2 && k == 60) while (pending_hits.size() != 0) @(negedge i_clk);
            end
            calm = 0;
        end
        // zero count after running
        wait_drained();
        write_reg(rsnh_pkg::CFG_SEG_COUNT, 24'd0);
        put_item(cast_item(1));

        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (errors == 0 && pending_hits.size() == 0)
            $display("ray_segment_nearest_hit_top: match");
        else
            $display("ray_segment_nearest_hit_top: mismatch");
        $finish;
    end
endmodule

>>> filelist.f
design/rsnh_pkg.sv
design/rsnh_ram.sv
design/rsnh_muldiv.sv
design/ray_segment_nearest_hit_top.sv
sim/ray_segment_nearest_hit_top_test.sv
